/* rtl/sfcr_pkg.sv */
// Shared constants and types for the serial frame checksum receiver.
package sfcr_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 64;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned INDEX_W           = 6;
  localparam int unsigned COUNT_W           = 32;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

/* rtl/sfcr_if.sv */
// Valid/ready channel interfaces for received bytes and frame results.
interface sfcr_in_if;
  logic             valid;
  logic             ready;
  sfcr_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcr_out_if;
  logic             valid;
  logic             ready;
  sfcr_pkg::byte_t  payload_byte;
  sfcr_pkg::index_t byte_index;
  logic             last_byte;
  logic             frame_ok;
  sfcr_pkg::count_t good_frame_count;
  sfcr_pkg::count_t bad_frame_count;

  modport source (output valid, output payload_byte, output byte_index, output last_byte,
                  output frame_ok, output good_frame_count, output bad_frame_count,
                  input ready);
  modport sink   (input valid, input payload_byte, input byte_index, input last_byte,
                  input frame_ok, input good_frame_count, input bad_frame_count,
                  output ready);
endinterface

/* rtl/serial_frame_checksum_receiver.sv */
// Top level of the start-byte framed receiver with additive checksum check.
//
// Takes one serial byte per word on in_ch. While idle it hunts for the byte
// held in the start register (written through cfg_wr_en / cfg_wr_data, reset
// 0); that byte opens a frame and gives no result. The next PAYLOAD_BYTES
// bytes are payload and each comes out on out_ch with its position (low six
// bits). A start byte inside a frame is plain data, there is no resync. The
// final payload byte is the checksum, compared unsigned with the modulo-256
// sum of the bytes before it; its word carries last_byte, frame_ok and the
// good/bad frame counters, both wrapping at 2^32 and already including this
// frame. Bytes outside a frame are dropped silently. Throughput is one byte
// per clock; a payload byte passes through the input register and then the
// result register, with the frame state updated as a byte moves from the
// first to the second. Back-pressure on out_ch stalls a payload byte in the
// input register, which then holds in_ch.ready low. Write the start register
// only while no byte is in flight.
module serial_frame_checksum_receiver #(
  parameter int unsigned PAYLOAD_BYTES = sfcr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  sfcr_pkg::byte_t   cfg_wr_data,
  sfcr_in_if.sink           in_ch,
  sfcr_out_if.source        out_ch
);

  // frame position: 0 idle, else 1 + payload bytes taken so far
  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned IDX_W = (POS_W > sfcr_pkg::INDEX_W) ? POS_W : sfcr_pkg::INDEX_W;

  sfcr_pkg::byte_t  start_byte_r;

  // input register
  logic             in_vld_r;
  sfcr_pkg::byte_t  in_byte_r;

  // frame state
  logic [POS_W-1:0] pos_r,  pos_nxt;
  sfcr_pkg::byte_t  sum_r,  sum_nxt;
  sfcr_pkg::count_t good_r, good_nxt;
  sfcr_pkg::count_t bad_r,  bad_nxt;

  // result register
  logic             out_vld_r;
  sfcr_pkg::byte_t  out_byte_r;
  sfcr_pkg::index_t out_idx_r;
  logic             out_last_r;
  logic             out_ok_r;

  logic             in_frame;
  logic             is_last;
  logic             sum_match;
  logic             emit;
  logic             out_free;
  logic             advance;
  logic [IDX_W-1:0] idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= '0;
    end else if (cfg_wr_en) begin
      start_byte_r <= cfg_wr_data;
    end
  end

  assign in_frame  = (pos_r != '0);
  assign is_last   = (pos_r == POS_W'(PAYLOAD_BYTES));
  assign sum_match = (sum_r == in_byte_r);
  assign idx_ext   = IDX_W'(pos_r) - IDX_W'(1);

  // only payload bytes need a slot in the result register
  assign emit     = in_vld_r && in_frame;
  assign out_free = !out_vld_r || out_ch.ready;
  assign advance  = in_vld_r && (!in_frame || out_free);

  assign in_ch.ready = !in_vld_r || advance;

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    good_nxt = good_r;
    bad_nxt  = bad_r;
    if (advance) begin
      if (!in_frame) begin
        if (in_byte_r == start_byte_r) begin
          pos_nxt = POS_W'(1);
          sum_nxt = '0;
        end
      end else if (is_last) begin
        pos_nxt = '0;
        sum_nxt = '0;
        if (sum_match) begin
          good_nxt = good_r + sfcr_pkg::count_t'(1);
        end else begin
          bad_nxt = bad_r + sfcr_pkg::count_t'(1);
        end
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        sum_nxt = sum_r + in_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      pos_r     <= '0;
      sum_r     <= '0;
      good_r    <= '0;
      bad_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      good_r <= good_nxt;
      bad_r  <= bad_nxt;
      if (out_free) begin
        out_vld_r <= advance && emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance && emit) begin
      out_byte_r <= in_byte_r;
      out_idx_r  <= idx_ext[sfcr_pkg::INDEX_W-1:0];
      out_last_r <= is_last;
      out_ok_r   <= is_last && sum_match;
    end
  end

  // counters in the result word are the live values, updated with the word
  assign out_ch.valid            = out_vld_r;
  assign out_ch.payload_byte     = out_byte_r;
  assign out_ch.byte_index       = out_idx_r;
  assign out_ch.last_byte        = out_last_r;
  assign out_ch.frame_ok         = out_ok_r;
  assign out_ch.good_frame_count = good_r;
  assign out_ch.bad_frame_count  = bad_r;

endmodule

/* bench/sfcr_tb_pkg.sv */
`timescale 1ns / 1ps
// Frame scoreboard: predicts each result word from accepted bytes and checks the block's words.
package sfcr_tb_pkg;
  import sfcr_pkg::*;

  typedef struct packed {
    byte_t  payload_byte;
    index_t byte_index;
    logic   last_byte;
    logic   frame_ok;
    count_t good_count;
    count_t bad_count;
  } frame_word_t;

  class frame_scoreboard;
    byte_t       start_val;
    int unsigned frame_pos;   // 0 while hunting, else 1 + payload bytes taken
    byte_t       byte_sum;
    count_t      good_frames;
    count_t      bad_frames;
    frame_word_t due_words[$];
    int unsigned errors;

    function new();
      start_val   = '0;
      frame_pos   = 0;
      byte_sum    = '0;
      good_frames = '0;
      bad_frames  = '0;
      errors      = 0;
    endfunction

    function void set_start(byte_t v);
      start_val = v;
    endfunction

    function void note_byte(byte_t b);
      frame_word_t w;
      if (frame_pos == 0) begin
        if (b == start_val) begin
          frame_pos = 1;
          byte_sum  = '0;
        end
        return;
      end
      w.payload_byte = b;
      w.byte_index   = index_t'(frame_pos - 1);
      w.last_byte    = (frame_pos >= PAYLOAD_BYTES_DEF);
      w.frame_ok     = 1'b0;
      if (w.last_byte) begin
        w.frame_ok = (byte_sum == b);
        if (w.frame_ok) begin
          good_frames = good_frames + 1'b1;
        end else begin
          bad_frames = bad_frames + 1'b1;
        end
        frame_pos = 0;
        byte_sum  = '0;
      end else begin
        byte_sum  = byte_sum + b;
        frame_pos = frame_pos + 1;
      end
      w.good_count = good_frames;
      w.bad_count  = bad_frames;
      due_words.push_back(w);
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      bit          wrong;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: unexpected word: byte %02h idx %0d last %0b ok %0b good %0d bad %0d",
                   got.payload_byte, got.byte_index, got.last_byte, got.frame_ok,
                   got.good_count, got.bad_count);
        end
        return;
      end
      want  = due_words.pop_front();
      wrong = (got.payload_byte !== want.payload_byte) || (got.byte_index !== want.byte_index) ||
              (got.last_byte !== want.last_byte) || (got.frame_ok !== want.frame_ok) ||
              (got.good_count !== want.good_count) || (got.bad_count !== want.bad_count);
      if (wrong) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: mismatch: want byte %02h idx %0d last %0b ok %0b good %0d bad %0d",
                   want.payload_byte, want.byte_index, want.last_byte, want.frame_ok,
                   want.good_count, want.bad_count);
          $display("tb:           got  byte %02h idx %0d last %0b ok %0b good %0d bad %0d",
                   got.payload_byte, got.byte_index, got.last_byte, got.frame_ok,
                   got.good_count, got.bad_count);
        end
      end
    endfunction
  endclass

endpackage

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top of the bench: clock, reset, byte stimulus, result back-pressure and the verdict.
module tb;
  import sfcr_pkg::*;
  import sfcr_tb_pkg::*;

  localparam int unsigned PHASES          = 6;
  localparam int unsigned BYTES_PER_PHASE = 220;
  // margin past the input and result registers; covers a dropped byte still in the input register
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_wr_en;
  byte_t cfg_wr_data;

  sfcr_in_if  in_ch ();
  sfcr_out_if out_ch ();

  serial_frame_checksum_receiver i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  frame_scoreboard frame_sb;
  byte_t           start_now;        // start byte the block currently holds
  int unsigned     src_idle_pct;
  int unsigned     snk_idle_pct;
  int unsigned     cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // A word moves at a rising edge with valid and ready both high; values read
  // here are the ones settled before the edge.
  always @(posedge clk) begin : take_word
    frame_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.payload_byte = out_ch.payload_byte;
      got.byte_index   = out_ch.byte_index;
      got.last_byte    = out_ch.last_byte;
      got.frame_ok     = out_ch.frame_ok;
      got.good_count   = out_ch.good_frame_count;
      got.bad_count    = out_ch.bad_frame_count;
      frame_sb.check_word(got);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offers one byte, with random gaps before it; entered and left at a falling edge.
  task automatic push_byte(input byte_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    frame_sb.note_byte(b);
    @(negedge clk);
  endtask

  // Line noise while hunting: never the start byte, so framing stays aligned.
  task automatic push_noise();
    byte_t b;
    b = byte_t'($urandom_range(255));
    if (b == start_now) b = b ^ 8'h01;
    push_byte(b);
  endtask

  // Start byte, payload, then the checksum. Extremes mode walks 00 / FF /
  // start byte through the payload; otherwise the content is random with those
  // values favoured, and now and then the frame is cut short so that the next
  // start byte lands inside it as plain data.
  task automatic push_frame(input bit good, input bit extremes, output int unsigned sent);
    byte_t       b;
    byte_t       sum;
    int unsigned len;
    bit          cut;
    len = PAYLOAD_BYTES_DEF - 1;
    cut = !extremes && ($urandom_range(11) == 0);
    if (cut) len = $urandom_range(len - 1);
    push_byte(start_now);
    sum  = '0;
    sent = 1;
    for (int i = 0; i < len; i++) begin
      if (extremes) begin
        case (i % 3)
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = start_now;
        endcase
      end else begin
        case ($urandom_range(7))
          0:       b = start_now;
          1:       b = 8'h00;
          2:       b = 8'hFF;
          default: b = byte_t'($urandom_range(255));
        endcase
      end
      push_byte(b);
      sum  = sum + b;
      sent = sent + 1;
    end
    if (!cut) begin
      b = good ? sum : sum + byte_t'($urandom_range(255, 1));
      push_byte(b);
      sent = sent + 1;
    end
  endtask

  // Lets every expected word out, then waits the DRAIN_CYCLES margin for a dropped byte.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (frame_sb.due_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start(input byte_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    frame_sb.set_start(v);
    start_now = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    byte_t       start_plan [PHASES];
    int unsigned sent;
    int unsigned got;
    frame_sb      = new();
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    start_now     = '0;
    src_idle_pct  = 25;
    snk_idle_pct  = 65;

    // phase 0 runs on the reset value of the start register
    start_plan[0] = 8'h00;
    start_plan[1] = 8'hFF;
    start_plan[2] = 8'h00;
    start_plan[3] = byte_t'($urandom_range(255));
    start_plan[4] = 8'h55;
    start_plan[5] = byte_t'($urandom_range(255));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin
          src_idle_pct = 25;
          snk_idle_pct = 65;
        end
        1: begin
          src_idle_pct = 65;
          snk_idle_pct = 25;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      if (ph != 0) begin
        drain();
        write_start(start_plan[ph]);
      end
      if (ph == 0) begin
        // directed: bytes dropped while hunting, then a good and a bad frame
        // with extreme payload, start byte repeated as data
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h01);
        push_frame(1'b1, 1'b1, got);
        push_frame(1'b0, 1'b1, got);
      end
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        repeat ($urandom_range(2)) push_noise();
        push_frame($urandom_range(3) != 0, 1'b0, got);
        sent = sent + got;
      end
    end

    drain();
    if (frame_sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
